[src/shm_pkg.sv]
// ----------------------------------------------------------------------------
// shm_pkg: shared types and constants of the skeleton height match block
// Field widths, segment and register codes, saturation limits, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package shm_pkg;

    localparam int USER_W     = 4;
    localparam int SEG_W      = 3;
    localparam int COORD_W    = 16;
    localparam int CONF_W     = 9;
    localparam int CCONF_W    = 10;
    localparam int LEN_W      = 17;
    localparam int HEIGHT_W   = 16;
    localparam int SCORE_W    = 16;
    localparam int MIN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SQ_W       = 34;
    localparam int PROD_W     = 32;
    localparam int ROOT_STEPS = 17;
    localparam int SQ_STEPS   = 3;
    localparam int QUOT_STEPS = 16;

    localparam logic [CONF_W-1:0]   CONF_MAX   = 9'd256;
    localparam logic [LEN_W-1:0]    LEN_MAX    = 17'h1FFFF;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFFFF;
    localparam logic [SCORE_W-1:0]  SCORE_FULL = 16'd32768;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_L0    = 3'd0;
    localparam logic [SEG_W-1:0] SEG_L1    = 3'd1;
    localparam logic [SEG_W-1:0] SEG_L2    = 3'd2;
    localparam logic [SEG_W-1:0] SEG_R0    = 3'd3;
    localparam logic [SEG_W-1:0] SEG_R1    = 3'd4;
    localparam logic [SEG_W-1:0] SEG_R2    = 3'd5;
    localparam logic [SEG_W-1:0] SEG_HEAD  = 3'd6;
    localparam logic [SEG_W-1:0] SEG_TORSO = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN       = 2'd3;

    localparam logic [15:0]      RST_TEMPLATE  = 16'd0;
    localparam logic [15:0]      RST_TOLERANCE = 16'd50;
    localparam logic [15:0]      RST_LIMIT     = 16'd200;
    localparam logic [MIN_W-1:0] RST_MIN       = 5'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ABS, ST_SQ, ST_ROOT, ST_CHAIN, ST_HGT, ST_WUPD, ST_MINIT,
        ST_MEAN, ST_CMP, ST_CLS, ST_MULN, ST_MULD, ST_QDIV, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_ZERO, KIND_FULL, KIND_QUOT
    } t_kind;

    typedef struct packed {
        logic        load;
        logic        sq_step;
        logic [1:0]  sq_sel;
        logic        root_step;
        logic        chain_upd;
        logic        hgt;
        logic        win_upd;
        logic        clear_user;
        logic        mean_init;
        logic        div_step;
        logic        cmp;
        logic        muln;
        logic        muld;
        logic        out_load;
        t_kind       out_kind;
    } t_cmd;

    typedef struct packed {
        logic user_ok;
        logic in_present;
        logic seg_last;
        logic too_few;
        logic cls_zero;
        logic cls_full;
        logic out_free;
    } t_status;

    // |a - b| of two signed coordinates
    function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    function automatic logic [CONF_W-1:0] conf_clamp(logic [CONF_W-1:0] c);
        return (c > CONF_MAX) ? CONF_MAX : c;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W:0] s);
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

[src/shm_if.sv]
// ----------------------------------------------------------------------------
// shm_if: channel interfaces of the skeleton height match block
// Joint-pair input channel, score output channel and register write channel.
// ----------------------------------------------------------------------------
interface shm_in_if;
    logic                          valid;
    logic                          ready;
    logic [shm_pkg::USER_W-1:0]    user;
    logic                          present;
    logic [shm_pkg::SEG_W-1:0]     segment;
    logic signed [shm_pkg::COORD_W-1:0] ax;
    logic signed [shm_pkg::COORD_W-1:0] ay;
    logic signed [shm_pkg::COORD_W-1:0] az;
    logic signed [shm_pkg::COORD_W-1:0] bx;
    logic signed [shm_pkg::COORD_W-1:0] by;
    logic signed [shm_pkg::COORD_W-1:0] bz;
    logic [shm_pkg::CONF_W-1:0]    conf_a;
    logic [shm_pkg::CONF_W-1:0]    conf_b;
    modport source (output valid, user, present, segment, ax, ay, az, bx, by, bz,
                    conf_a, conf_b, input ready);
    modport sink (input valid, user, present, segment, ax, ay, az, bx, by, bz,
                  conf_a, conf_b, output ready);
endinterface

interface shm_out_if;
    logic                          valid;
    logic                          ready;
    logic [shm_pkg::USER_W-1:0]    out_user;
    logic [shm_pkg::SCORE_W-1:0]   score;
    logic [shm_pkg::HEIGHT_W-1:0]  frame_height;
    modport source (output valid, out_user, score, frame_height, input ready);
    modport sink (input valid, out_user, score, frame_height, output ready);
endinterface

interface shm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [shm_pkg::CFG_IDX_W-1:0]   index;
    logic [shm_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/shm_ram.sv]
// ----------------------------------------------------------------------------
// shm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module shm_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/shm_ctrl.sv]
// ----------------------------------------------------------------------------
// shm_ctrl: sequencer of the skeleton height match block
// Steps the datapath through squares, root, chain update, window update,
// mean division, classification and score division.
// ----------------------------------------------------------------------------
module shm_ctrl #(
    parameter int WINDOW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  shm_pkg::t_status i_st,
    output shm_pkg::t_cmd    o_cmd
);
    localparam int SW   = 16 + $clog2(WINDOW);
    localparam int KMAX = (SW > shm_pkg::ROOT_STEPS) ? SW : shm_pkg::ROOT_STEPS;
    localparam int KW   = $clog2(KMAX + 1);

    shm_pkg::t_state r_state, n_state;
    shm_pkg::t_kind  r_kind, n_kind;
    logic [KW-1:0]   r_k, n_k;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shm_pkg::ST_IDLE;
            r_kind  <= shm_pkg::KIND_ZERO;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_k     <= n_k;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            shm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_k        = '0;
                    if (!i_st.user_ok) begin
                        n_state = shm_pkg::ST_IDLE;
                    end else if (!i_st.in_present) begin
                        n_state = shm_pkg::ST_ABS;
                    end else begin
                        n_state = shm_pkg::ST_SQ;
                    end
                end
            end
            shm_pkg::ST_ABS: begin
                o_cmd.clear_user = 1'b1;
                n_kind           = shm_pkg::KIND_ZERO;
                n_state          = shm_pkg::ST_DONE;
            end
            shm_pkg::ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                o_cmd.sq_sel  = r_k[1:0];
                if (r_k == KW'(shm_pkg::SQ_STEPS - 1)) begin
                    n_k     = '0;
                    n_state = shm_pkg::ST_ROOT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            shm_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_k == KW'(shm_pkg::ROOT_STEPS - 1)) begin
                    n_k     = '0;
                    n_state = shm_pkg::ST_CHAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            shm_pkg::ST_CHAIN: begin
                o_cmd.chain_upd = 1'b1;
                n_state = i_st.seg_last ? shm_pkg::ST_HGT : shm_pkg::ST_IDLE;
            end
            shm_pkg::ST_HGT: begin
                o_cmd.hgt = 1'b1;
                n_state   = shm_pkg::ST_WUPD;
            end
            shm_pkg::ST_WUPD: begin
                o_cmd.win_upd = 1'b1;
                n_state       = shm_pkg::ST_MINIT;
            end
            shm_pkg::ST_MINIT: begin
                if (i_st.too_few) begin
                    n_kind  = shm_pkg::KIND_ZERO;
                    n_state = shm_pkg::ST_DONE;
                end else begin
                    o_cmd.mean_init = 1'b1;
                    n_k             = '0;
                    n_state         = shm_pkg::ST_MEAN;
                end
            end
            shm_pkg::ST_MEAN: begin
                o_cmd.div_step = 1'b1;
                if (r_k == KW'(SW - 1)) begin
                    n_k     = '0;
                    n_state = shm_pkg::ST_CMP;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            shm_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = shm_pkg::ST_CLS;
            end
            shm_pkg::ST_CLS: begin
                if (i_st.cls_zero) begin
                    n_kind  = shm_pkg::KIND_ZERO;
                    n_state = shm_pkg::ST_DONE;
                end else if (i_st.cls_full) begin
                    n_kind  = shm_pkg::KIND_FULL;
                    n_state = shm_pkg::ST_DONE;
                end else begin
                    n_state = shm_pkg::ST_MULN;
                end
            end
            shm_pkg::ST_MULN: begin
                o_cmd.muln = 1'b1;
                n_state    = shm_pkg::ST_MULD;
            end
            shm_pkg::ST_MULD: begin
                o_cmd.muld = 1'b1;
                n_k        = '0;
                n_state    = shm_pkg::ST_QDIV;
            end
            shm_pkg::ST_QDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_k == KW'(shm_pkg::QUOT_STEPS - 1)) begin
                    n_k     = '0;
                    n_kind  = shm_pkg::KIND_QUOT;
                    n_state = shm_pkg::ST_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            shm_pkg::ST_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_kind;
                    n_state        = shm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shm_pkg::ST_IDLE;
            end
        endcase
    end

    // window write always follows the height cycle
    a_wupd_after_hgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.win_upd |-> $past(r_state) == shm_pkg::ST_HGT)
        else $error("window update without height cycle");

    // root iteration count stays in range
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shm_pkg::ST_ROOT) |-> (r_k < KW'(shm_pkg::ROOT_STEPS)))
        else $error("root step counter overrun");

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_st.out_free)
        else $error("output register overwritten");
endmodule

[src/shm_dp.sv]
// ----------------------------------------------------------------------------
// shm_dp: datapath of the skeleton height match block
// Squares and root of segment length, chain registers, per-user window
// memories, shared multiplier and shared restoring divider, output register.
// ----------------------------------------------------------------------------
module shm_dp #(
    parameter int USERS  = 16,
    parameter int WINDOW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  shm_pkg::t_cmd                     i_cmd,
    output shm_pkg::t_status                  o_st,
    input  logic [shm_pkg::USER_W-1:0]        i_user,
    input  logic                              i_present,
    input  logic [shm_pkg::SEG_W-1:0]         i_segment,
    input  logic signed [shm_pkg::COORD_W-1:0] i_ax,
    input  logic signed [shm_pkg::COORD_W-1:0] i_ay,
    input  logic signed [shm_pkg::COORD_W-1:0] i_az,
    input  logic signed [shm_pkg::COORD_W-1:0] i_bx,
    input  logic signed [shm_pkg::COORD_W-1:0] i_by,
    input  logic signed [shm_pkg::COORD_W-1:0] i_bz,
    input  logic [shm_pkg::CONF_W-1:0]        i_conf_a,
    input  logic [shm_pkg::CONF_W-1:0]        i_conf_b,
    input  logic                              i_cfg_valid,
    input  logic [shm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [shm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_out_ready,
    output logic [shm_pkg::USER_W-1:0]        o_user,
    output logic [shm_pkg::SCORE_W-1:0]       o_score,
    output logic [shm_pkg::HEIGHT_W-1:0]      o_height
);
    localparam int UIW  = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int WD   = USERS * WINDOW;
    localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
    localparam int HW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SW   = 16 + $clog2(WINDOW);
    localparam int SW1  = SW + 1;
    localparam int USW  = CW + HW + SW;
    localparam int PW   = shm_pkg::PROD_W;

    // configuration registers
    logic [15:0]               r_tpl, r_tol, r_lim;
    logic [shm_pkg::MIN_W-1:0] r_min;
    logic [shm_pkg::MIN_W-1:0] need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpl <= shm_pkg::RST_TEMPLATE;
            r_tol <= shm_pkg::RST_TOLERANCE;
            r_lim <= shm_pkg::RST_LIMIT;
            r_min <= shm_pkg::RST_MIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                shm_pkg::CFG_TEMPLATE:  r_tpl <= i_cfg_data;
                shm_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data;
                shm_pkg::CFG_LIMIT:     r_lim <= i_cfg_data;
                shm_pkg::CFG_MIN:       r_min <= i_cfg_data[shm_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign need = (r_min == '0) ? shm_pkg::MIN_W'(1) : r_min;

    // input transaction latch
    logic [shm_pkg::USER_W-1:0]  r_user;
    logic                        r_present;
    logic [shm_pkg::SEG_W-1:0]   r_seg;
    logic [15:0]                 r_dx, r_dy, r_dz;
    logic [shm_pkg::CONF_W-1:0]  r_conf;
    logic [shm_pkg::CONF_W-1:0]  ca, cb;

    assign ca = shm_pkg::conf_clamp(i_conf_a);
    assign cb = shm_pkg::conf_clamp(i_conf_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_user    <= i_user;
            r_present <= i_present;
            r_seg     <= i_segment;
            r_dx      <= shm_pkg::abs_diff(i_ax, i_bx);
            r_dy      <= shm_pkg::abs_diff(i_ay, i_by);
            r_dz      <= shm_pkg::abs_diff(i_az, i_bz);
            r_conf    <= (ca < cb) ? ca : cb;
        end
    end

    // shared multiplier
    logic [15:0]   mul_a;
    logic [PW-1:0] mul_p;
    logic [15:0]   r_d;
    logic [15:0]   num, den;

    assign num = r_lim - r_d;
    assign den = r_lim - r_tol;

    always_comb begin
        if (i_cmd.muln) begin
            mul_a = num;
        end else if (i_cmd.muld) begin
            mul_a = den;
        end else begin
            case (i_cmd.sq_sel)
                2'd0:    mul_a = r_dx;
                2'd1:    mul_a = r_dy;
                default: mul_a = r_dz;
            endcase
        end
    end

    assign mul_p = mul_a * mul_a;

    // sum of squares and bitwise square root
    logic [shm_pkg::SQ_W-1:0]  r_acc;
    logic [shm_pkg::LEN_W-1:0] r_root;
    logic [19:0]               r_rem;
    logic [19:0]               rt_r2, rt_t;

    assign rt_r2 = {r_rem[17:0], r_acc[shm_pkg::SQ_W-1 -: 2]};
    assign rt_t  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc  <= '0;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.sq_step) begin
            r_acc <= r_acc + shm_pkg::SQ_W'(mul_p);
        end else if (i_cmd.root_step) begin
            r_acc <= r_acc << 2;
            if (rt_r2 >= rt_t) begin
                r_rem  <= rt_r2 - rt_t;
                r_root <= {r_root[shm_pkg::LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= rt_r2;
                r_root <= {r_root[shm_pkg::LEN_W-2:0], 1'b0};
            end
        end
    end

    // chain registers, shared by all users
    logic [shm_pkg::LEN_W-1:0]   r_left, r_right, r_spine;
    logic [shm_pkg::CCONF_W-1:0] r_lconf, r_rconf;
    logic [shm_pkg::CCONF_W-1:0] conf10;

    assign conf10 = shm_pkg::CCONF_W'(r_conf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_spine <= '0;
            r_lconf <= '0;
            r_rconf <= '0;
        end else if (i_cmd.chain_upd) begin
            case (r_seg)
                shm_pkg::SEG_L0: begin
                    r_left  <= r_root;
                    r_lconf <= conf10;
                end
                shm_pkg::SEG_L1, shm_pkg::SEG_L2: begin
                    r_left  <= shm_pkg::sat_len({1'b0, r_left} + {1'b0, r_root});
                    r_lconf <= r_lconf + conf10;
                end
                shm_pkg::SEG_R0: begin
                    r_right <= r_root;
                    r_rconf <= conf10;
                end
                shm_pkg::SEG_R1, shm_pkg::SEG_R2: begin
                    r_right <= shm_pkg::sat_len({1'b0, r_right} + {1'b0, r_root});
                    r_rconf <= r_rconf + conf10;
                end
                shm_pkg::SEG_HEAD: begin
                    r_spine <= r_root;
                end
                default: begin
                    r_spine <= shm_pkg::sat_len({1'b0, r_spine} + {1'b0, r_root});
                end
            endcase
        end
    end

    // frame height
    logic [shm_pkg::LEN_W-1:0]    leg;
    logic [shm_pkg::LEN_W:0]      leg_pair, hsum;
    logic [shm_pkg::HEIGHT_W-1:0] height_n, r_height;

    always_comb begin
        leg_pair = {1'b0, r_left} + {1'b0, r_right};
        if (r_rconf > r_lconf) begin
            leg = r_right;
        end else if (r_lconf > r_rconf) begin
            leg = r_left;
        end else begin
            leg = leg_pair[shm_pkg::LEN_W:1];
        end
        hsum = {1'b0, leg} + {1'b0, r_spine};
        height_n = (hsum > (shm_pkg::LEN_W + 1)'(shm_pkg::HEIGHT_MAX)) ?
                   shm_pkg::HEIGHT_MAX : hsum[shm_pkg::HEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hgt) begin
            r_height <= height_n;
        end
    end

    // per-user window state: valid bits plus state memory
    logic [UIW-1:0]   u_idx;
    logic [USERS-1:0] r_valid;
    logic [USW-1:0]   us_rd, us_wd;
    logic [CW-1:0]    cur_cnt, cnt_n, r_cnt;
    logic [HW-1:0]    cur_head, head_n;
    logic [SW-1:0]    cur_sum, sum_n, r_sum;
    logic [WAW-1:0]   slot;
    logic [15:0]      win_rd;

    assign u_idx = UIW'(r_user);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.win_upd) begin
            r_valid[u_idx] <= 1'b1;
        end else if (i_cmd.clear_user) begin
            r_valid[u_idx] <= 1'b0;
        end
    end

    assign cur_cnt  = r_valid[u_idx] ? us_rd[USW-1 -: CW] : '0;
    assign cur_head = r_valid[u_idx] ? us_rd[SW +: HW] : '0;
    assign cur_sum  = r_valid[u_idx] ? us_rd[SW-1:0] : '0;
    assign slot     = WAW'(int'(u_idx) * WINDOW + int'(cur_head));

    always_comb begin
        head_n = (cur_head == HW'(WINDOW - 1)) ? '0 : cur_head + 1'b1;
        if (cur_cnt >= CW'(WINDOW)) begin
            cnt_n = cur_cnt;
            sum_n = SW'(SW1'(cur_sum) - SW1'(win_rd) + SW1'(r_height));
        end else begin
            cnt_n = cur_cnt + 1'b1;
            sum_n = SW'(SW1'(cur_sum) + SW1'(r_height));
        end
        us_wd = {cnt_n, head_n, sum_n};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_upd) begin
            r_cnt <= cnt_n;
            r_sum <= sum_n;
        end
    end

    shm_ram #(.W(USW), .DEPTH(USERS)) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_upd),
        .i_waddr (u_idx),
        .i_wdata (us_wd),
        .i_raddr (u_idx),
        .o_rdata (us_rd)
    );

    shm_ram #(.W(16), .DEPTH(WD)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_upd),
        .i_waddr (slot),
        .i_wdata (r_height),
        .i_raddr (slot),
        .o_rdata (win_rd)
    );

    // shared restoring divider: mean, then score quotient
    logic [PW-1:0] r_drem, r_div;
    logic [SW-1:0] r_q;
    logic [PW:0]   dv_r2;
    logic          dv_ge;

    assign dv_r2 = {r_drem, r_q[SW-1]};
    assign dv_ge = dv_r2 >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_init) begin
            r_drem <= '0;
            r_q    <= r_sum;
            r_div  <= PW'(r_cnt);
        end else if (i_cmd.muln) begin
            r_drem <= mul_p;
            r_q    <= '0;
        end else if (i_cmd.muld) begin
            r_div <= mul_p;
        end else if (i_cmd.div_step) begin
            r_drem <= dv_ge ? PW'(dv_r2 - {1'b0, r_div}) : dv_r2[PW-1:0];
            r_q    <= {r_q[SW-2:0], dv_ge};
        end
    end

    // distance of window mean from template
    logic [15:0] mean;

    assign mean = r_q[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_d <= (mean > r_tpl) ? mean - r_tpl : r_tpl - mean;
        end
    end

    // output register
    logic                         r_ovalid;
    logic [shm_pkg::USER_W-1:0]   r_ouser;
    logic [shm_pkg::SCORE_W-1:0]  r_oscore;
    logic [shm_pkg::HEIGHT_W-1:0] r_oheight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ouser   <= r_user;
            r_oheight <= r_present ? r_height : '0;
            case (i_cmd.out_kind)
                shm_pkg::KIND_FULL: r_oscore <= shm_pkg::SCORE_FULL;
                shm_pkg::KIND_QUOT: r_oscore <= {1'b0, r_q[15:1]};
                default:            r_oscore <= '0;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_user   = r_ouser;
    assign o_score  = r_oscore;
    assign o_height = r_oheight;

    // status to the controller
    always_comb begin
        o_st.user_ok    = int'(i_user) < USERS;
        o_st.in_present = i_present;
        o_st.seg_last   = (r_seg == shm_pkg::SEG_TORSO);
        o_st.too_few    = 8'(r_cnt) < 8'(need);
        o_st.cls_zero   = (r_d > r_lim) || ((r_d >= r_tol) && (r_lim == r_tol));
        o_st.cls_full   = (r_d <= r_lim) &&
                          ((r_d < r_tol) || ((r_d == r_tol) && (r_lim != r_tol)));
        o_st.out_free   = !r_ovalid || i_out_ready;
    end

    // score stays within Q15 full scale
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oscore <= shm_pkg::SCORE_FULL))
        else $error("score above full scale");

    // ratio numerator only formed inside the limit
    a_num_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.muln |-> (r_d <= r_lim) && (r_d > r_tol))
        else $error("score ratio outside interpolation band");
endmodule

[src/skeleton_height_match.sv]
// ----------------------------------------------------------------------------
// skeleton_height_match: body height match score for tracked users
// Top level joining the sequencer and the datapath to the channels.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : joint-pair transactions, eight per frame (segments 0..7) for one
//            user, or one absence transaction that clears the user's window.
//   o_out  : one score transaction after segment 7 or after an absence.
//   i_cfg  : register writes (template, tolerance, limit, min samples),
//            always ready; write only while the block is idle.
//   Items are handled one at a time; ready is high while the sequencer idles.
//   Segments 0..6 pass through the latch, three squares through the shared
//   multiplier, 17 root iterations and the chain update. Segment 7 adds the
//   frame height, the window update, a mean division and, when the distance
//   lies between tolerance and limit, a score division.
//   Users at or above USERS are taken and dropped.
//   A finished score waits in the output register; the next item is taken
//   meanwhile, and the sequencer only holds if a second score is ready
//   before the first one has gone.
//   Reset clears the chains, all user windows (per-user valid bits) and the
//   registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module skeleton_height_match #(
    parameter int USERS  = 16,
    parameter int WINDOW = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    shm_in_if.sink    i_in,
    shm_out_if.source o_out,
    shm_cfg_if.sink   i_cfg
);
    shm_pkg::t_cmd    cmd;
    shm_pkg::t_status st;
    logic             in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer
    shm_ctrl #(.WINDOW(WINDOW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath
    shm_dp #(.USERS(USERS), .WINDOW(WINDOW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_user      (i_in.user),
        .i_present   (i_in.present),
        .i_segment   (i_in.segment),
        .i_ax        (i_in.ax),
        .i_ay        (i_in.ay),
        .i_az        (i_in.az),
        .i_bx        (i_in.bx),
        .i_by        (i_in.by),
        .i_bz        (i_in.bz),
        .i_conf_a    (i_in.conf_a),
        .i_conf_b    (i_in.conf_b),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_valid     (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_user      (o_out.out_user),
        .o_score     (o_out.score),
        .o_height    (o_out.frame_height)
    );
endmodule
